@@ rtl/core/mi3_pkg.sv @@
// Types and constants shared by the 3x3 matrix inverse pipeline.
package mi3_pkg;

   localparam int ELEM_WIDTH = 16;
   localparam int PROD_W     = 2 * ELEM_WIDTH;
   localparam int ADJ_W      = PROD_W + 1;
   localparam int TERM_W     = ELEM_WIDTH + ADJ_W;
   localparam int DET_W      = TERM_W + 2;
   localparam int MAG_W      = ADJ_W - 1;
   localparam int FRAC_SHIFT = 28;
   localparam int QUO_W      = 33;
   localparam int PRE_SHIFT  = QUO_W - FRAC_SHIFT;
   localparam int OUT_W      = 32;
   localparam int THRESH_W   = 40;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 40'd687195;

   localparam int FRONT_STAGES = 4;
   localparam int NUM_STAGES   = FRONT_STAGES + 1 + QUO_W + 1;

   // Cofactor k is e[A]*e[B] - e[C]*e[D].
   localparam int COF_A [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam int COF_B [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   localparam int COF_C [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam int COF_D [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

   typedef struct packed {
      logic signed [ELEM_WIDTH-1:0] in_r1c1;
      logic signed [ELEM_WIDTH-1:0] in_r1c2;
      logic signed [ELEM_WIDTH-1:0] in_r1c3;
      logic signed [ELEM_WIDTH-1:0] in_r2c1;
      logic signed [ELEM_WIDTH-1:0] in_r2c2;
      logic signed [ELEM_WIDTH-1:0] in_r2c3;
      logic signed [ELEM_WIDTH-1:0] in_r3c1;
      logic signed [ELEM_WIDTH-1:0] in_r3c2;
      logic signed [ELEM_WIDTH-1:0] in_r3c3;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] out_r1c1;
      logic signed [OUT_W-1:0] out_r1c2;
      logic signed [OUT_W-1:0] out_r1c3;
      logic signed [OUT_W-1:0] out_r2c1;
      logic signed [OUT_W-1:0] out_r2c2;
      logic signed [OUT_W-1:0] out_r2c3;
      logic signed [OUT_W-1:0] out_r3c1;
      logic signed [OUT_W-1:0] out_r3c2;
      logic signed [OUT_W-1:0] out_r3c3;
      logic                    singular;
      logic                    saturated;
   } rsp_type;

   typedef struct packed {
      logic [DET_W-1:0] rem;
      logic [QUO_W-1:0] nb;
      logic [QUO_W-1:0] quo;
      logic             ovf;
      logic             neg;
   } lane_type;

   typedef struct packed {
      logic [DET_W-1:0] dmag;
      logic             sing;
      lane_type [8:0]   lane;
   } div_type;

endpackage

@@ rtl/core/matrix_3x3_inverse.sv @@
// Throughput: one matrix per cycle while the output is not stalled; the 33-stage restoring divider sets the depth.
// Each stage advances whenever the stage after it is empty or advancing.
// Synchronous active-high reset empties the pipeline and loads the default
// singular threshold.
// Top level: adjugate, determinant and pipelined division for a 3x3 inverse.
module matrix_3x3_inverse (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  mi3_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output mi3_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [mi3_pkg::THRESH_W-1:0]        csr_wdata
);

   localparam int NS = mi3_pkg::NUM_STAGES;
   localparam int FS = mi3_pkg::FRONT_STAGES;
   localparam int QW = mi3_pkg::QUO_W;
   localparam int DW = mi3_pkg::DET_W;

   logic [mi3_pkg::THRESH_W-1:0] thresh_ff;
   logic [NS-1:0]                vld_ff;
   logic [NS-1:0]                en;

   logic signed [mi3_pkg::ELEM_WIDTH-1:0] e [9];

   logic signed [mi3_pkg::PROD_W-1:0]     prod_ff [18];
   logic signed [mi3_pkg::ELEM_WIDTH-1:0] e1_ff [3];
   logic signed [mi3_pkg::ADJ_W-1:0]      adj_in [9];
   logic signed [mi3_pkg::ADJ_W-1:0]      adj_ff [9];
   logic signed [mi3_pkg::ELEM_WIDTH-1:0] e2_ff [3];
   logic signed [mi3_pkg::TERM_W-1:0]     term_ff [3];
   logic signed [mi3_pkg::ADJ_W-1:0]      adj3_ff [9];

   logic signed [DW-1:0]          det;
   logic [DW-1:0]                 dmag4_in, dmag4_ff;
   logic                          dneg;
   logic                          sing4_ff;
   logic [mi3_pkg::MAG_W-1:0]     am_in [9];
   logic [mi3_pkg::MAG_W-1:0]     am_ff [9];
   logic [8:0]                    neg4_in, neg4_ff;

   mi3_pkg::div_type div_in [QW+1];
   mi3_pkg::div_type div_ff [QW+1];

   mi3_pkg::rsp_type rsp_in, rsp_ff;
   logic [mi3_pkg::OUT_W-1:0] res [9];
   logic [8:0]                lane_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= mi3_pkg::THRESH_RESET;
      end else if (csr_we) begin
         thresh_ff <= csr_wdata;
      end
   end

   always_comb begin
      en[NS-1] = !vld_ff[NS-1] || !rsp_stall;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = vld_ff[NS-1];
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   assign e[0] = req_data.in_r1c1;
   assign e[1] = req_data.in_r1c2;
   assign e[2] = req_data.in_r1c3;
   assign e[3] = req_data.in_r2c1;
   assign e[4] = req_data.in_r2c2;
   assign e[5] = req_data.in_r2c3;
   assign e[6] = req_data.in_r3c1;
   assign e[7] = req_data.in_r3c2;
   assign e[8] = req_data.in_r3c3;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int k = 0; k < 9; k++) begin
            prod_ff[2*k]   <= e[mi3_pkg::COF_A[k]] * e[mi3_pkg::COF_B[k]];
            prod_ff[2*k+1] <= e[mi3_pkg::COF_C[k]] * e[mi3_pkg::COF_D[k]];
         end
         for (int k = 0; k < 3; k++) begin
            e1_ff[k] <= e[k];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         adj_in[k] = mi3_pkg::ADJ_W'(prod_ff[2*k]) - mi3_pkg::ADJ_W'(prod_ff[2*k+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         adj_ff <= adj_in;
         e2_ff  <= e1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         term_ff[0] <= e2_ff[0] * adj_ff[0];
         term_ff[1] <= e2_ff[1] * adj_ff[3];
         term_ff[2] <= e2_ff[2] * adj_ff[6];
         adj3_ff    <= adj_ff;
      end
   end

   always_comb begin
      det      = DW'(term_ff[0]) + DW'(term_ff[1]) + DW'(term_ff[2]);
      dneg     = det[DW-1];
      dmag4_in = dneg ? DW'(-det) : DW'(det);
      for (int k = 0; k < 9; k++) begin
         am_in[k]   = adj3_ff[k][mi3_pkg::ADJ_W-1] ?
                      mi3_pkg::MAG_W'(-adj3_ff[k]) : mi3_pkg::MAG_W'(adj3_ff[k]);
         neg4_in[k] = adj3_ff[k][mi3_pkg::ADJ_W-1] ^ dneg;
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         dmag4_ff <= dmag4_in;
         sing4_ff <= (dmag4_in <= DW'(thresh_ff));
         am_ff    <= am_in;
         neg4_ff  <= neg4_in;
      end
   end

   always_comb begin
      div_in[0].dmag = dmag4_ff;
      div_in[0].sing = sing4_ff;
      for (int k = 0; k < 9; k++) begin
         div_in[0].lane[k].rem = DW'(am_ff[k][mi3_pkg::MAG_W-1:mi3_pkg::PRE_SHIFT]);
         div_in[0].lane[k].ovf =
            DW'(am_ff[k][mi3_pkg::MAG_W-1:mi3_pkg::PRE_SHIFT]) >= dmag4_ff;
         div_in[0].lane[k].nb  =
            {am_ff[k][mi3_pkg::PRE_SHIFT-1:0], mi3_pkg::FRAC_SHIFT'(0)};
         div_in[0].lane[k].quo = '0;
         div_in[0].lane[k].neg = neg4_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en[FS]) begin
         div_ff[0] <= div_in[0];
      end
   end

   for (genvar j = 1; j <= QW; j++) begin : g_div
      logic [DW:0] r2   [9];
      logic        ge   [9];

      always_comb begin
         div_in[j].dmag = div_ff[j-1].dmag;
         div_in[j].sing = div_ff[j-1].sing;
         for (int k = 0; k < 9; k++) begin
            r2[k] = {div_ff[j-1].lane[k].rem, div_ff[j-1].lane[k].nb[QW-1]};
            ge[k] = r2[k] >= {1'b0, div_ff[j-1].dmag};
            div_in[j].lane[k].rem = ge[k] ? DW'(r2[k] - {1'b0, div_ff[j-1].dmag})
                                          : DW'(r2[k]);
            div_in[j].lane[k].nb  = {div_ff[j-1].lane[k].nb[QW-2:0], 1'b0};
            div_in[j].lane[k].quo = {div_ff[j-1].lane[k].quo[QW-2:0], ge[k]};
            div_in[j].lane[k].ovf = div_ff[j-1].lane[k].ovf;
            div_in[j].lane[k].neg = div_ff[j-1].lane[k].neg;
         end
      end

      always_ff @(posedge clock) begin
         if (en[FS+j]) begin
            div_ff[j] <= div_in[j];
         end
      end
   end

   always_comb begin
      logic [QW:0] qr;
      logic [QW:0] limit;
      logic [mi3_pkg::OUT_W-1:0] v;
      qr    = '0;
      limit = '0;
      v     = '0;
      for (int k = 0; k < 9; k++) begin
         qr = {1'b0, div_ff[QW].lane[k].quo} +
              (QW+1)'({div_ff[QW].lane[k].rem, 1'b0} >= {1'b0, div_ff[QW].dmag});
         limit = div_ff[QW].lane[k].neg ? (QW+1)'(34'h080000000)
                                        : (QW+1)'(34'h07FFFFFFF);
         lane_sat[k] = div_ff[QW].lane[k].ovf || (qr > limit);
         v = lane_sat[k] ? mi3_pkg::OUT_W'(limit) : mi3_pkg::OUT_W'(qr);
         res[k] = div_ff[QW].sing ? '0 : (div_ff[QW].lane[k].neg ? -v : v);
      end
      rsp_in.out_r1c1  = res[0];
      rsp_in.out_r1c2  = res[1];
      rsp_in.out_r1c3  = res[2];
      rsp_in.out_r2c1  = res[3];
      rsp_in.out_r2c2  = res[4];
      rsp_in.out_r2c3  = res[5];
      rsp_in.out_r3c1  = res[6];
      rsp_in.out_r3c2  = res[7];
      rsp_in.out_r3c3  = res[8];
      rsp_in.singular  = div_ff[QW].sing;
      rsp_in.saturated = !div_ff[QW].sing && (|lane_sat);
   end

   always_ff @(posedge clock) begin
      if (en[NS-1]) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
